@@ src/relay_guard_pump_timer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Relay guard assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef RELAY_GUARD_PUMP_TIMER_CORE_MACROS_SVH
`define RELAY_GUARD_PUMP_TIMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RGPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rgpt assertion failed");
`define RGPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgpt assertion failed");
`else
`define RGPT_ASSERT(lbl, clk, rst_n, prop)
`define RGPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/rgpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Relay guard package
// Request and result payload types, operation codes, register map.
// ----------------------------------------------------------------------------
package rgpt_pkg;

  localparam int ADDR_W = 4;
  localparam int MS_W   = 26;
  localparam int MS_PER_S = 1000;

  localparam logic [1:0] OP_CMD      = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_PUMP_OFF = 2'd2;

  localparam logic [1:0] REG_ACTIVE_LOW  = 2'd0;
  localparam logic [1:0] REG_MAX_RUN     = 2'd1;
  localparam logic [1:0] REG_COOLDOWN    = 2'd2;
  localparam logic [1:0] REG_EMERG_TEMP  = 2'd3;

  localparam logic [15:0]        MAX_RUN_S_RST  = 16'd300;
  localparam logic [15:0]        COOLDOWN_S_RST = 16'd600;
  localparam logic signed [15:0] EMERG_TEMP_RST = 16'sd560;
  localparam logic [MS_W-1:0]    MAX_RUN_MS_RST  = MS_W'(300 * MS_PER_S);
  localparam logic [MS_W-1:0]    COOLDOWN_MS_RST = MS_W'(600 * MS_PER_S);

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic               want_fan;
    logic               want_cooler;
    logic               want_pump;
    logic               want_light;
    logic signed [15:0] temp;
    logic               temp_valid;
    logic               online;
  } rgpt_in_t;

  typedef struct packed {
    logic fan_pin;
    logic cooler_pin;
    logic pump_pin;
    logic light_pin;
    logic pump_refused;
  } rgpt_out_t;

endpackage

@@ src/rgpt_if.sv @@
// ----------------------------------------------------------------------------
// Relay guard channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rgpt_in_if;
  import rgpt_pkg::*;
  logic     valid;
  logic     ready;
  rgpt_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rgpt_out_if;
  import rgpt_pkg::*;
  logic      valid;
  logic      ready;
  rgpt_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ src/relay_guard_pump_timer_core.sv @@
// ----------------------------------------------------------------------------
// Relay guard pump timer core
// Four relays with polarity, pump run-time cutoff and cooldown lockout,
// and an offline over-temperature override.
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req_i    in   valid/ready    op, now_ms, want_*, temp, temp_valid, online
// rsp_o    out  valid/ready    fan/cooler/pump/light pins, pump_refused
// apb      in   psel/penable   4 config registers at 4*i
//
// One request per cycle unless an unclaimed result stalls the request stage.
// Request register feeds one pass of compare/add logic into the result register.
// Reset clears relays and timers and loads register defaults.
// Ready drops only while a result sits unclaimed and the request stage is full.
`include "relay_guard_pump_timer_core_macros.svh"

module relay_guard_pump_timer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rgpt_in_if.sink                    req_i,
  rgpt_out_if.source                 rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rgpt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rgpt_pkg::*;

  logic                active_low_q;
  logic [15:0]         max_run_s_q;
  logic [15:0]         cooldown_s_q;
  logic signed [15:0]  emerg_temp_q;
  logic [MS_W-1:0]     max_run_ms_q;
  logic [MS_W-1:0]     cooldown_ms_q;
  logic [MS_W-1:0]     wr_ms;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  logic        fan_q, cooler_q, pump_q, light_q;
  logic        fan_d, cooler_d, pump_d, light_d;
  logic [31:0] pump_start_q, pump_start_d;
  logic [31:0] cool_end_q, cool_end_d;
  logic [31:0] elapsed;
  logic        refused;

  logic      in_valid_q;
  rgpt_in_t  in_q;
  logic      out_valid_q;
  rgpt_out_t out_q;
  logic      advance;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign wr_ms   = MS_W'(pwdata[15:0]) * MS_W'(MS_PER_S);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= 1'b0;
      max_run_s_q   <= MAX_RUN_S_RST;
      cooldown_s_q  <= COOLDOWN_S_RST;
      emerg_temp_q  <= EMERG_TEMP_RST;
      max_run_ms_q  <= MAX_RUN_MS_RST;
      cooldown_ms_q <= COOLDOWN_MS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ACTIVE_LOW: active_low_q <= pwdata[0];
        REG_MAX_RUN: begin
          max_run_s_q  <= pwdata[15:0];
          max_run_ms_q <= wr_ms;
        end
        REG_COOLDOWN: begin
          cooldown_s_q  <= pwdata[15:0];
          cooldown_ms_q <= wr_ms;
        end
        REG_EMERG_TEMP: emerg_temp_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ACTIVE_LOW: prdata = {31'b0, active_low_q};
      REG_MAX_RUN:    prdata = {16'b0, max_run_s_q};
      REG_COOLDOWN:   prdata = {16'b0, cooldown_s_q};
      REG_EMERG_TEMP: prdata = {16'b0, emerg_temp_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !in_valid_q || advance;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.data;
    end
  end

  // state update
  assign elapsed = in_q.now_ms - pump_start_q;

  always_comb begin
    fan_d        = fan_q;
    cooler_d     = cooler_q;
    pump_d       = pump_q;
    light_d      = light_q;
    pump_start_d = pump_start_q;
    cool_end_d   = cool_end_q;
    refused      = 1'b0;
    case (in_q.op)
      OP_CMD: begin
        fan_d    = in_q.want_fan;
        cooler_d = in_q.want_cooler;
        light_d  = in_q.want_light;
        if (in_q.want_pump && !pump_q) begin
          if (in_q.now_ms >= cool_end_q) begin
            pump_d       = 1'b1;
            pump_start_d = in_q.now_ms;
          end else begin
            refused = 1'b1;
          end
        end else if (!in_q.want_pump && pump_q) begin
          pump_d       = 1'b0;
          pump_start_d = '0;
        end
      end
      OP_TICK: begin
        if (pump_q && (elapsed >= 32'(max_run_ms_q))) begin
          pump_d       = 1'b0;
          pump_start_d = '0;
          cool_end_d   = in_q.now_ms + 32'(cooldown_ms_q);
        end
        if (!in_q.online && in_q.temp_valid && (in_q.temp >= emerg_temp_q)) begin
          fan_d    = 1'b1;
          cooler_d = 1'b1;
        end
      end
      OP_PUMP_OFF: begin
        pump_d       = 1'b0;
        pump_start_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q        <= 1'b0;
      cooler_q     <= 1'b0;
      pump_q       <= 1'b0;
      light_q      <= 1'b0;
      pump_start_q <= '0;
      cool_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        fan_q        <= fan_d;
        cooler_q     <= cooler_d;
        pump_q       <= pump_d;
        light_q      <= light_d;
        pump_start_q <= pump_start_d;
        cool_end_q   <= cool_end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q.fan_pin      <= fan_d ^ active_low_q;
      out_q.cooler_pin   <= cooler_d ^ active_low_q;
      out_q.pump_pin     <= pump_d ^ active_low_q;
      out_q.light_pin    <= light_d ^ active_low_q;
      out_q.pump_refused <= refused;
    end
  end

  `RGPT_ASSERT(a_start_clear, clk_i, rst_ni, pump_q || (pump_start_q == '0))
  `RGPT_ASSERT(a_refused_off, clk_i, rst_ni,
               !(out_valid_q && out_q.pump_refused) || (out_q.pump_pin == active_low_q))
  `RGPT_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, advance && in_valid_q, out_valid_q)
  `RGPT_ASSERT_NEXT(a_refused_cmd_only, clk_i, rst_ni,
                    advance && in_valid_q && (in_q.op != OP_CMD), !out_q.pump_refused)

endmodule
